/* rtl/core/tts_pkg.sv */
// Package for the tick task scheduler table.
// Holds field widths, operation and status codes, and the table entry type.
// Used by the channel interfaces, the entry unit and the top level.
package tts_pkg;

  localparam int OpW         = 2;
  localparam int IdW         = 8;
  localparam int TickW       = 16;
  localparam int CountW      = 7;
  localparam int StatW       = 2;
  localparam int DefTableDepth = 8;

  typedef enum logic [OpW-1:0] {
    OP_SET      = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TICK     = 2'd2,
    OP_DISPATCH = 2'd3
  } op_t;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NULL_ID   = 2'd3
  } status_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TickW-1:0] delay;
    logic [TickW-1:0] period;
    logic             ready;
  } entry_t;

  typedef struct packed {
    logic   match;
    logic   ready;
    logic   one_shot;
    entry_t upd;
  } eu_res_t;

endpackage

/* rtl/core/tts_ifs.sv */
// Channel interfaces for the tick task scheduler table.
// Depends on tts_pkg for the payload widths.
interface tts_in_if;
  logic                        valid;
  logic                        ready;
  logic [tts_pkg::OpW-1:0]     operation;
  logic [tts_pkg::IdW-1:0]     task_id;
  logic [tts_pkg::TickW-1:0]   delay_ticks;
  logic [tts_pkg::TickW-1:0]   period_ticks;

  modport source (output valid, operation, task_id, delay_ticks, period_ticks, input ready);
  modport sink (input valid, operation, task_id, delay_ticks, period_ticks, output ready);
endinterface

interface tts_out_if;
  logic                        valid;
  logic                        ready;
  logic [tts_pkg::IdW-1:0]     ready_task;
  logic                        task_valid;
  logic [tts_pkg::StatW-1:0]   status;
  logic [tts_pkg::CountW-1:0]  task_count;
  logic                        last;

  modport source (output valid, ready_task, task_valid, status, task_count, last, input ready);
  modport sink (input valid, ready_task, task_valid, status, task_count, last, output ready);
endinterface

/* rtl/core/tick_task_scheduler_table_top.sv */
// Top level of the tick task scheduler table: sequencer, entry memory and result register.
// Depends on tts_pkg, tts_in_if, tts_out_if and tts_entry_unit.
//
// Usage: in_ch carries one operation per transaction (set, delete, tick, dispatch).
// out_ch returns the results; the final result of an operation has last set.
// Set, delete and tick give one result; dispatch gives one result per ready task,
// or one empty result when no task is ready.
// The table sits in a memory with one write port and a registered read port, and one
// entry unit is reused for every entry visited. Each visited entry is read (S_RD),
// then checked and written back (S_CHK); removing an entry adds a tail read and a
// tail write. Set or delete stops scanning once it finds its id, and set or delete
// with id zero goes straight to S_FIN without visiting the table. For each task it
// runs, dispatch passes through S_POST, after a tail read and write for a one-shot
// task. in_ch.ready is high only between operations. The result register lets a new
// operation be accepted while the final result of the previous one still waits.
// When out_ch stalls, the sequencer waits before placing another result. After reset
// the table is empty; entry contents need no clearing since only entries below the
// task count are ever used.
module tick_task_scheduler_table_top #(
  parameter int TABLE_DEPTH = tts_pkg::DefTableDepth
) (
  input  logic           clk,
  input  logic           rst_n,
  tts_in_if.sink         in_ch,
  tts_out_if.source      out_ch
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [tts_pkg::CountW-1:0] DepthC = tts_pkg::CountW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_TAIL_RD,
    S_TAIL_WR,
    S_POST,
    S_FIN
  } state_t;

  state_t                      state_r, state_nxt;
  tts_pkg::op_t                op_r, op_nxt;
  logic [tts_pkg::IdW-1:0]     id_r, id_nxt;
  logic [tts_pkg::TickW-1:0]   dly_r, dly_nxt;
  logic [tts_pkg::TickW-1:0]   per_r, per_nxt;
  logic [tts_pkg::CountW-1:0]  i_r, i_nxt;
  logic [tts_pkg::CountW-1:0]  count_r, count_nxt;
  tts_pkg::status_t            stat_r, stat_nxt;
  logic [tts_pkg::IdW-1:0]     run_id_r, run_id_nxt;
  logic                        pend_valid_r, pend_valid_nxt;
  logic [tts_pkg::IdW-1:0]     pend_id_r, pend_id_nxt;
  logic [tts_pkg::CountW-1:0]  pend_cnt_r, pend_cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [tts_pkg::IdW-1:0]     out_task_r, out_task_nxt;
  logic                        out_tv_r, out_tv_nxt;
  tts_pkg::status_t            out_stat_r, out_stat_nxt;
  logic [tts_pkg::CountW-1:0]  out_cnt_r, out_cnt_nxt;
  logic                        out_last_r, out_last_nxt;

  tts_pkg::entry_t             mem [TABLE_DEPTH];
  tts_pkg::entry_t             rd_data_r;
  logic [IdxW-1:0]             rd_addr;
  logic                        wr_en;
  logic [IdxW-1:0]             wr_addr;
  tts_pkg::entry_t             wr_data;

  tts_pkg::eu_res_t            eu;
  logic [tts_pkg::CountW-1:0]  tail;
  logic                        out_free;

  tts_entry_unit u_entry_unit (
    .ent    (rd_data_r),
    .op     (op_r),
    .key_id (id_r),
    .dly    (dly_r),
    .per    (per_r),
    .res    (eu)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign tail     = count_r - tts_pkg::CountW'(1);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    dly_nxt        = dly_r;
    per_nxt        = per_r;
    i_nxt          = i_r;
    count_nxt      = count_r;
    stat_nxt       = stat_r;
    run_id_nxt     = run_id_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    pend_cnt_nxt   = pend_cnt_r;
    out_valid_nxt  = out_valid_r;
    out_task_nxt   = out_task_r;
    out_tv_nxt     = out_tv_r;
    out_stat_nxt   = out_stat_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    rd_addr        = i_r[IdxW-1:0];
    wr_en          = 1'b0;
    wr_addr        = i_r[IdxW-1:0];
    wr_data        = eu.upd;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt         = tts_pkg::op_t'(in_ch.operation);
          id_nxt         = in_ch.task_id;
          dly_nxt        = in_ch.delay_ticks;
          per_nxt        = in_ch.period_ticks;
          i_nxt          = '0;
          pend_valid_nxt = 1'b0;
          stat_nxt       = tts_pkg::ST_OK;
          if ((in_ch.operation inside {tts_pkg::OP_SET, tts_pkg::OP_DELETE})
              && in_ch.task_id == '0) begin
            stat_nxt  = tts_pkg::ST_NULL_ID;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        if (i_r < count_r) begin
          state_nxt = S_CHK;
        end else begin
          state_nxt = S_FIN;
          case (op_r)
            tts_pkg::OP_SET: begin
              if (count_r >= DepthC) begin
                stat_nxt = tts_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = count_r[IdxW-1:0];
                count_nxt = count_r + tts_pkg::CountW'(1);
              end
            end
            tts_pkg::OP_DELETE: begin
              stat_nxt = tts_pkg::ST_NOT_FOUND;
            end
            default: begin
              stat_nxt = tts_pkg::ST_OK;
            end
          endcase
        end
      end
      S_CHK: begin
        case (op_r)
          tts_pkg::OP_SET: begin
            if (eu.match) begin
              wr_en     = 1'b1;
              state_nxt = S_FIN;
            end else begin
              i_nxt     = i_r + tts_pkg::CountW'(1);
              state_nxt = S_RD;
            end
          end
          tts_pkg::OP_DELETE: begin
            if (eu.match) begin
              state_nxt = S_TAIL_RD;
            end else begin
              i_nxt     = i_r + tts_pkg::CountW'(1);
              state_nxt = S_RD;
            end
          end
          tts_pkg::OP_TICK: begin
            wr_en     = 1'b1;
            i_nxt     = i_r + tts_pkg::CountW'(1);
            state_nxt = S_RD;
          end
          default: begin
            if (eu.ready) begin
              run_id_nxt = rd_data_r.id;
              if (eu.one_shot) begin
                state_nxt = S_TAIL_RD;
              end else begin
                wr_en     = 1'b1;
                state_nxt = S_POST;
              end
            end else begin
              i_nxt     = i_r + tts_pkg::CountW'(1);
              state_nxt = S_RD;
            end
          end
        endcase
      end
      S_TAIL_RD: begin
        rd_addr   = tail[IdxW-1:0];
        state_nxt = S_TAIL_WR;
      end
      S_TAIL_WR: begin
        wr_en     = 1'b1;
        wr_data   = rd_data_r;
        count_nxt = tail;
        state_nxt = (op_r == tts_pkg::OP_DELETE) ? S_FIN : S_POST;
      end
      S_POST: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_task_nxt  = pend_id_r;
            out_tv_nxt    = 1'b1;
            out_stat_nxt  = tts_pkg::ST_OK;
            out_cnt_nxt   = pend_cnt_r;
            out_last_nxt  = 1'b0;
          end
          pend_valid_nxt = 1'b1;
          pend_id_nxt    = run_id_r;
          pend_cnt_nxt   = count_r;
          i_nxt          = i_r + tts_pkg::CountW'(1);
          state_nxt      = S_RD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_task_nxt  = pend_valid_r ? pend_id_r : '0;
          out_tv_nxt    = pend_valid_r;
          out_stat_nxt  = stat_r;
          out_cnt_nxt   = pend_valid_r ? pend_cnt_r : count_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    dly_r      <= dly_nxt;
    per_r      <= per_nxt;
    i_r        <= i_nxt;
    stat_r     <= stat_nxt;
    run_id_r   <= run_id_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_cnt_r <= pend_cnt_nxt;
    out_task_r <= out_task_nxt;
    out_tv_r   <= out_tv_nxt;
    out_stat_r <= out_stat_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.ready_task = out_task_r;
  assign out_ch.task_valid = out_tv_r;
  assign out_ch.status     = out_stat_r;
  assign out_ch.task_count = out_cnt_r;
  assign out_ch.last       = out_last_r;

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DepthC)
    else $error("task count exceeds table depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while an operation is in progress");

  a_task_result_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.task_valid) |-> (out_ch.status == tts_pkg::ST_OK))
    else $error("dispatched task carries a non-ok status");

endmodule

/* rtl/core/tts_entry_unit.sv */
// Shared entry unit: id compare, flag tests and one decrementer for a table entry.
// Produces the updated entry for set, tick and dispatch. Depends on tts_pkg.
module tts_entry_unit (
  input  tts_pkg::entry_t                ent,
  input  tts_pkg::op_t                   op,
  input  logic [tts_pkg::IdW-1:0]        key_id,
  input  logic [tts_pkg::TickW-1:0]      dly,
  input  logic [tts_pkg::TickW-1:0]      per,
  output tts_pkg::eu_res_t               res
);

  logic                      delay_zero;
  logic [tts_pkg::TickW-1:0] dec_src;
  logic [tts_pkg::TickW-1:0] dec;

  assign delay_zero = (ent.delay == '0);
  assign dec_src    = (op == tts_pkg::OP_TICK) ? ent.delay : ent.period;
  assign dec        = dec_src - tts_pkg::TickW'(1);

  always_comb begin
    res.match    = (ent.id == key_id);
    res.ready    = ent.ready;
    res.one_shot = (ent.period == '0);
    res.upd      = ent;
    case (op)
      tts_pkg::OP_SET: begin
        res.upd.id     = key_id;
        res.upd.delay  = dly;
        res.upd.period = per;
        res.upd.ready  = 1'b0;
      end
      tts_pkg::OP_TICK: begin
        if (delay_zero) begin
          res.upd.ready = 1'b1;
        end else begin
          res.upd.delay = dec;
        end
      end
      tts_pkg::OP_DISPATCH: begin
        res.upd.ready = 1'b0;
        if (delay_zero) begin
          res.upd.delay = dec;
        end
      end
      default: begin
        res.upd = ent;
      end
    endcase
  end

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for tick_task_scheduler_table_top.
// It drives set, delete, tick and dispatch transactions, predicts every result from its own
// copy of the task table, and checks the result channel. Depends on tts_pkg and tts_ifs.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tts_pkg::*;

  localparam int DEPTH        = DefTableDepth;
  localparam int RANDOM_OPS   = 387;
  localparam int TAIL_ITEMS   = 60;
  localparam int HOLD_AT      = 140;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_AT     = 260;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE       = 60;
  localparam int PRINT_CAP    = 40;

  typedef struct {
    op_t              op;
    logic [IdW-1:0]   id;
    logic [TickW-1:0] dly;
    logic [TickW-1:0] per;
    bit               drain;
  } sched_op_t;

  typedef struct {
    logic [IdW-1:0]    ready_task;
    logic              task_valid;
    status_t           status;
    logic [CountW-1:0] task_count;
    logic              last;
  } sched_res_t;

  logic clk;
  logic rst_n;

  tts_in_if  in_ch ();
  tts_out_if out_ch ();

  tick_task_scheduler_table_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sched_op_t  op_queue[$];
  sched_res_t awaited[$];
  sched_op_t  offered;

  logic [IdW-1:0]   tbl_id     [DEPTH];
  logic [TickW-1:0] tbl_delay  [DEPTH];
  logic [TickW-1:0] tbl_period [DEPTH];
  logic             tbl_ready  [DEPTH];
  int               tbl_count;

  int mismatches;
  int n_accepted;
  bit tail_phase;
  int src_gap;
  int src_gap_pct;
  int snk_gap;
  int snk_gap_pct;
  int hold_left;
  bit hold_done;
  int quiet;

  function automatic int pick_pace();
    int r;
    r = $urandom_range(0, 2);
    return (r == 0) ? 0 : ((r == 1) ? 8 : 30);
  endfunction

  function automatic void add_due(logic [IdW-1:0] task_id, logic valid, status_t st, logic last);
    sched_res_t r;
    r.ready_task = task_id;
    r.task_valid = valid;
    r.status     = st;
    r.task_count = tbl_count[CountW-1:0];
    r.last       = last;
    awaited.push_back(r);
  endfunction

  function automatic int find_slot(logic [IdW-1:0] id);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(int i);
    int tail;
    tail = tbl_count - 1;
    if (i != tail) begin
      tbl_id[i]     = tbl_id[tail];
      tbl_delay[i]  = tbl_delay[tail];
      tbl_period[i] = tbl_period[tail];
      tbl_ready[i]  = tbl_ready[tail];
    end
    tbl_count = tail;
  endfunction

  // Applies one accepted transaction to the shadow table and queues the results it causes.
  function automatic void run_table_op(sched_op_t t);
    int idx;
    int hits;
    logic [IdW-1:0] run_id;
    case (t.op)
      OP_SET: begin
        if (t.id == '0) begin
          add_due('0, 1'b0, ST_NULL_ID, 1'b1);
        end else begin
          idx = find_slot(t.id);
          if (idx < 0 && tbl_count >= DEPTH) begin
            add_due('0, 1'b0, ST_FULL, 1'b1);
          end else begin
            if (idx < 0) begin
              idx = tbl_count;
              tbl_id[idx] = t.id;
              tbl_count++;
            end
            tbl_delay[idx]  = t.dly;
            tbl_period[idx] = t.per;
            tbl_ready[idx]  = 1'b0;
            add_due('0, 1'b0, ST_OK, 1'b1);
          end
        end
      end
      OP_DELETE: begin
        if (t.id == '0) begin
          add_due('0, 1'b0, ST_NULL_ID, 1'b1);
        end else begin
          idx = find_slot(t.id);
          if (idx < 0) begin
            add_due('0, 1'b0, ST_NOT_FOUND, 1'b1);
          end else begin
            drop_slot(idx);
            add_due('0, 1'b0, ST_OK, 1'b1);
          end
        end
      end
      OP_TICK: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_delay[i] == '0) tbl_ready[i] = 1'b1;
          else tbl_delay[i] = tbl_delay[i] - 1'b1;
        end
        add_due('0, 1'b0, ST_OK, 1'b1);
      end
      default: begin
        hits = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_ready[i]) begin
            run_id = tbl_id[i];
            if (tbl_period[i] == '0) begin
              drop_slot(i);
            end else begin
              tbl_ready[i] = 1'b0;
              if (tbl_delay[i] == '0) tbl_delay[i] = tbl_period[i] - 1'b1;
            end
            add_due(run_id, 1'b1, ST_OK, 1'b0);
            hits++;
          end
        end
        if (hits == 0) add_due('0, 1'b0, ST_OK, 1'b1);
        else awaited[awaited.size()-1].last = 1'b1;
      end
    endcase
  endfunction

  function automatic void queue_op(op_t op, int id, int dly, int per, bit drain = 1'b0);
    sched_op_t t;
    t.op    = op;
    t.id    = id[IdW-1:0];
    t.dly   = dly[TickW-1:0];
    t.per   = per[TickW-1:0];
    t.drain = drain;
    op_queue.push_back(t);
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    int r;
    int s;
    op_t op;
    int id;
    int dly;
    int per;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_TICK;
    in_ch.task_id       = '0;
    in_ch.delay_ticks   = '0;
    in_ch.period_ticks  = '0;
    out_ch.ready        = 1'b0;
    mismatches          = 0;
    tbl_count           = 0;

    queue_op(OP_SET, 0, 5, 5);
    queue_op(OP_DELETE, 0, 0, 0);
    queue_op(OP_DELETE, 5, 0, 0);
    queue_op(OP_SET, 255, 0, 0);
    queue_op(OP_SET, 1, 0, 1);
    queue_op(OP_SET, 2, 1, 0);
    queue_op(OP_SET, 128, 0, 16'hFFFF);
    queue_op(OP_SET, 3, 16'hFFFF, 16'hFFFF);
    queue_op(OP_SET, 4, 0, 0);
    queue_op(OP_SET, 5, 2, 3);
    queue_op(OP_SET, 6, 0, 0);
    queue_op(OP_SET, 7, 0, 0);
    queue_op(OP_SET, 3, 0, 2);
    queue_op(OP_DISPATCH, 0, 0, 0);
    queue_op(OP_TICK, 0, 0, 0);
    queue_op(OP_TICK, 0, 0, 0);
    queue_op(OP_DISPATCH, 0, 0, 0);
    queue_op(OP_TICK, 0, 0, 0);
    queue_op(OP_DISPATCH, 0, 0, 0);
    queue_op(OP_DELETE, 128, 0, 0);
    queue_op(OP_DELETE, 1, 0, 0);
    queue_op(OP_TICK, 0, 0, 0);
    queue_op(OP_DISPATCH, 0, 0, 0);

    for (int k = 0; k < RANDOM_OPS; k++) begin
      r = $urandom_range(0, 99);
      if (r < 35) op = OP_SET;
      else if (r < 50) op = OP_DELETE;
      else if (r < 75) op = OP_TICK;
      else op = OP_DISPATCH;
      s = $urandom_range(0, 19);
      if (s == 0) id = 0;
      else if (s == 1) id = $urandom_range(0, 255);
      else id = $urandom_range(1, 12);
      s = $urandom_range(0, 9);
      dly = (s == 0) ? int'($urandom & 16'hFFFF) : $urandom_range(0, 4);
      s = $urandom_range(0, 9);
      if (s == 0) per = $urandom & 16'hFFFF;
      else if (s < 4) per = 0;
      else per = $urandom_range(1, 5);
      queue_op(op, id, dly, per, k == DRAIN_AT);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || in_ch.valid) @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      n_accepted  <= 0;
      tail_phase  <= 1'b0;
      src_gap     = 0;
      src_gap_pct = pick_pace();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        run_table_op(offered);
        n_accepted <= n_accepted + 1;
      end
      tail_phase <= (op_queue.size() < TAIL_ITEMS);
      if (in_ch.valid && !in_ch.ready) begin
        // The current transaction stays on the bus until it is taken.
      end else if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (op_queue.size() == 0 || (op_queue[0].drain && awaited.size() != 0)) begin
        in_ch.valid <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 99) < src_gap_pct) begin
        src_gap = $urandom_range(1, 13) - 1;
        in_ch.valid <= 1'b0;
      end else begin
        offered = op_queue.pop_front();
        if ($urandom_range(0, 39) == 0) src_gap_pct = pick_pace();
        in_ch.valid        <= 1'b1;
        in_ch.operation    <= offered.op;
        in_ch.task_id      <= offered.id;
        in_ch.delay_ticks  <= offered.dly;
        in_ch.period_ticks <= offered.per;
      end
    end
  end

  // The long hold-off lets the block fill up and stall its input while items keep coming.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    = 0;
      hold_done    = 1'b0;
      snk_gap      = 0;
      snk_gap_pct  = pick_pace();
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      snk_gap--;
      out_ch.ready <= 1'b0;
    end else if (!tail_phase && $urandom_range(0, 99) < snk_gap_pct) begin
      snk_gap = $urandom_range(1, 13) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) snk_gap_pct = pick_pace();
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sched_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected result, ready_task %0d status %0d",
                                  out_ch.ready_task, out_ch.status));
      end else begin
        want = awaited.pop_front();
        check_field("ready_task", out_ch.ready_task, want.ready_task);
        check_field("task_valid", out_ch.task_valid, want.task_valid);
        check_field("status", out_ch.status, want.status);
        check_field("task_count", out_ch.task_count, want.task_count);
        check_field("last", out_ch.last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
